FILE: rtl/core/spt_pkg.sv
package spt_pkg;

    localparam int CLADE_W   = 16;
    localparam int NODE_ID_W = 5;
    localparam int LP_W      = 32;
    localparam int SUM_W     = 36;
    localparam int SLOT_W    = 4;
    localparam int IDX_W     = 10;

    localparam logic [NODE_ID_W-1:0] NO_CHILD = 5'd31;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_PARENT = 2'd1,
        CMD_LPROB  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [0:0] {
        REG_TAXA    = 1'b0,
        REG_ENTRIES = 1'b1
    } t_reg;

    // search unit response
    typedef struct packed {
        logic done;
        logic found;
    } t_srch_rsp;

endpackage

FILE: rtl/core/spt_table.sv
module spt_table #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_we_key,
    input  logic                                  i_we_val,
    input  logic [$clog2(MAX_ENTRIES)-1:0]        i_waddr,
    input  logic [2*spt_pkg::CLADE_W-1:0]         i_wkey,
    input  logic [spt_pkg::LP_W-1:0]              i_wval,
    input  logic                                  i_start,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0]      i_limit,
    input  logic [2*spt_pkg::CLADE_W-1:0]         i_key,
    output spt_pkg::t_srch_rsp                    o_rsp,
    output logic [$clog2(MAX_ENTRIES)-1:0]        o_idx,
    output logic [spt_pkg::LP_W-1:0]              o_val
);
    import spt_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int KW = 2 * CLADE_W;

    logic [KW-1:0]   mem_key [MAX_ENTRIES];
    logic [LP_W-1:0] mem_val [MAX_ENTRIES];

    logic            r_run;
    logic [AW-1:0]   r_addr;
    logic            r_rd_vld;
    logic            r_rd_end;
    logic [AW-1:0]   r_rd_idx;
    logic [KW-1:0]   r_rd_key;
    logic [LP_W-1:0] r_rd_val;
    logic            hit;

    // write ports
    always_ff @(posedge i_clk) begin
        if (i_we_key) begin
            mem_key[i_waddr] <= i_wkey;
        end
        if (i_we_val) begin
            mem_val[i_waddr] <= i_wval;
        end
    end

    // registered read of the scanned entry
    always_ff @(posedge i_clk) begin
        r_rd_key <= mem_key[r_addr];
        r_rd_val <= mem_val[r_addr];
        r_rd_idx <= r_addr;
        r_rd_end <= (r_addr == '0);
    end

    assign hit = r_rd_vld && (r_rd_key == i_key);

    // scan downward from the top entry, first hit is the highest index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_rd_vld <= 1'b0;
            r_addr   <= '0;
        end else if (i_start) begin
            r_run    <= 1'b1;
            r_rd_vld <= 1'b0;
            r_addr   <= AW'(i_limit - 1'b1);
        end else if (hit || (r_rd_vld && r_rd_end)) begin
            r_run    <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_run;
            if (r_run) begin
                if (r_addr == '0) begin
                    r_run <= 1'b0;
                end else begin
                    r_addr <= r_addr - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done  = hit || (r_rd_vld && r_rd_end);
    assign o_rsp.found = hit;
    assign o_idx       = r_rd_idx;
    assign o_val       = r_rd_val;

`ifndef SYNTHESIS
    a_no_scan_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> !r_rd_vld && r_run)
        else $error("scan did not restart");
    a_done_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.done && !i_start) |=> !r_rd_vld)
        else $error("scan kept going after done");
    a_found_has_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.found |-> o_rsp.done)
        else $error("hit without done");
`endif

endmodule

FILE: rtl/core/subsplit_topology_log_prob.sv
// Channel  | Direction | Handshake                    | Payload
// input    | in        | i_in_valid / o_in_ready      | i_cmd .. i_last
// result   | out       | o_out_valid / i_out_ready    | o_internal_slot .. o_last_res
// config   | in        | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_wdata
//
// Table writes and parent links are taken while the block is idle.
// The last parent item of a tree rebuilds clades, ST_CLADE_A then ST_CLADE_B per internal
// node; then per internal node come the child reads, a table scan of up to E entries (E =
// entries searched, one entry per cycle through the table read port) and the emit.
// Reset is synchronous, active low; the table contents are not cleared.
// A stalled result holds the output register; emission of the next node waits for it.
module subsplit_topology_log_prob #(
    parameter int MAX_TAXA    = 16,
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [10:0]                     i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_cmd,
    input  logic [spt_pkg::IDX_W-1:0]       i_entry_index,
    input  logic [spt_pkg::CLADE_W-1:0]     i_parent_clade_bits,
    input  logic [spt_pkg::CLADE_W-1:0]     i_child_clade_bits,
    input  logic signed [spt_pkg::LP_W-1:0] i_entry_log_prob,
    input  logic [spt_pkg::NODE_ID_W-1:0]   i_parent_node,
    input  logic                            i_last,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [spt_pkg::SLOT_W-1:0]      o_internal_slot,
    output logic [spt_pkg::IDX_W-1:0]       o_matched_index,
    output logic                            o_status,
    output logic signed [spt_pkg::SUM_W-1:0] o_log_prob_total,
    output logic                            o_last_res
);
    import spt_pkg::*;

    localparam int CAP        = (MAX_TAXA < 16) ? MAX_TAXA : 16;
    localparam int NODE_SLOTS = 2 * CAP - 1;
    localparam int INT_SLOTS  = CAP - 1;
    localparam int NW         = $clog2(NODE_SLOTS);
    localparam int SW         = (INT_SLOTS > 1) ? $clog2(INT_SLOTS) : 1;
    localparam int AW         = $clog2(MAX_ENTRIES);
    localparam int LW         = $clog2(MAX_ENTRIES + 1);
    localparam int KW         = 2 * CLADE_W;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_CLADE_A = 7'b0000010,
        ST_CLADE_B = 7'b0000100,
        ST_SCORE_A = 7'b0001000,
        ST_SCORE_B = 7'b0010000,
        ST_SEARCH  = 7'b0100000,
        ST_EMIT    = 7'b1000000
    } t_state;

    t_state                r_state;
    logic [4:0]            r_taxa;
    logic [10:0]           r_entries;
    logic [NODE_ID_W-1:0]  r_first  [INT_SLOTS];
    logic [NODE_ID_W-1:0]  r_second [INT_SLOTS];
    logic [CLADE_W-1:0]    r_clades [NODE_SLOTS];
    logic [NODE_ID_W-1:0]  r_next;
    logic [NODE_ID_W-1:0]  r_i;
    logic [CLADE_W-1:0]    r_c0;
    logic [KW-1:0]         r_key;
    logic signed [SUM_W-1:0] r_sum;
    logic                  r_found;
    logic [AW-1:0]         r_idx;

    logic                  r_out_vld;
    logic [SLOT_W-1:0]     r_out_slot;
    logic [IDX_W-1:0]      r_out_idx;
    logic                  r_out_stat;
    logic [SUM_W-1:0]      r_out_sum;
    logic                  r_out_last;

    logic [NODE_ID_W-1:0]  eff_n;
    logic [NODE_ID_W-1:0]  nodes;
    logic [NODE_ID_W-1:0]  slot_full;
    logic [SW-1:0]         slot;
    logic [NODE_ID_W-1:0]  sel_child;
    logic [CLADE_W-1:0]    cl;
    logic [CLADE_W-1:0]    low0;
    logic [CLADE_W-1:0]    low1;
    logic [CLADE_W-1:0]    canon;
    logic [LW-1:0]         limit;
    logic                  in_xfer;
    logic                  emit_go;
    logic                  srch_start;
    logic [SUM_W:0]        sum_wide;
    logic [SUM_W-1:0]      sum_sat;
    logic [NODE_ID_W-1:0]  pslot_full;
    logic                  link_ok;
    logic                  tbl_idx_ok;
    t_srch_rsp             srch;
    logic [AW-1:0]         srch_idx;
    logic [LP_W-1:0]       srch_val;

    // clamp taxa count and derive node count
    always_comb begin
        if (r_taxa < 5'd2) begin
            eff_n = 5'd2;
        end else if (32'(r_taxa) > CAP) begin
            eff_n = NODE_ID_W'(CAP);
        end else begin
            eff_n = r_taxa;
        end
        nodes = NODE_ID_W'({1'b0, eff_n, 1'b0} - 7'd1);
    end

    always_comb begin
        if (32'(r_entries) >= MAX_ENTRIES) begin
            limit = LW'(MAX_ENTRIES);
        end else begin
            limit = LW'(r_entries);
        end
    end

    // shared child clade read
    assign slot_full = r_i - eff_n;
    assign slot      = SW'(slot_full);
    assign sel_child = (r_state == ST_CLADE_A || r_state == ST_SCORE_A) ?
                       r_first[slot] : r_second[slot];
    assign cl        = (sel_child < nodes) ? r_clades[NW'(sel_child)] : '0;

    // canonical child: lower lowest taxon, empty clade counts as lowest
    assign low0  = r_c0 & (~r_c0 + 1'b1);
    assign low1  = cl & (~cl + 1'b1);
    assign canon = (low0 < low1) ? r_c0 : cl;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign emit_go    = (r_state == ST_EMIT) && (!r_out_vld || i_out_ready);
    assign srch_start = (r_state == ST_SCORE_B) && (limit != '0);

    assign pslot_full = i_parent_node - eff_n;
    assign link_ok    = (r_next < nodes - 1'b1) && (i_parent_node >= eff_n) &&
                        (i_parent_node < nodes);
    assign tbl_idx_ok = 32'(i_entry_index) < MAX_ENTRIES;

    // saturating add of the matched log-prob
    assign sum_wide = {r_sum[SUM_W-1], r_sum} +
                      {{(SUM_W + 1 - LP_W){srch_val[LP_W-1]}}, srch_val};
    always_comb begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat = {sum_wide[SUM_W], {(SUM_W - 1){~sum_wide[SUM_W]}}};
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    spt_table #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we_key(in_xfer && i_cmd == CMD_WRITE && tbl_idx_ok),
        .i_we_val(in_xfer && (i_cmd == CMD_WRITE || i_cmd == CMD_LPROB) && tbl_idx_ok),
        .i_waddr (AW'(i_entry_index)),
        .i_wkey  ({i_parent_clade_bits, i_child_clade_bits}),
        .i_wval  (i_entry_log_prob),
        .i_start (srch_start),
        .i_limit (limit),
        .i_key   (r_key),
        .o_rsp   (srch),
        .o_idx   (srch_idx),
        .o_val   (srch_val)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taxa    <= 5'd16;
            r_entries <= 11'd1024;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TAXA:    r_taxa    <= i_cfg_wdata[4:0];
                REG_ENTRIES: r_entries <= i_cfg_wdata;
                default:     r_entries <= r_entries;
            endcase
        end
    end

    // sequencer, links and clades
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_next  <= '0;
            r_i     <= '0;
            r_sum   <= '0;
            for (int j = 0; j < INT_SLOTS; j++) begin
                r_first[j]  <= NO_CHILD;
                r_second[j] <= NO_CHILD;
            end
            for (int j = 0; j < NODE_SLOTS; j++) begin
                r_clades[j] <= '0;
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer && i_cmd == CMD_PARENT) begin
                        if (link_ok) begin
                            if (r_first[SW'(pslot_full)] == NO_CHILD) begin
                                r_first[SW'(pslot_full)] <= r_next;
                            end else begin
                                r_second[SW'(pslot_full)] <= r_next;
                            end
                        end
                        if (r_next != NO_CHILD) begin
                            r_next <= r_next + 1'b1;
                        end
                        if (i_last) begin
                            for (int j = 0; j < NODE_SLOTS; j++) begin
                                r_clades[j] <= (j < 32'(eff_n)) ? CLADE_W'(1 << j) : '0;
                            end
                            r_i     <= eff_n;
                            r_state <= ST_CLADE_A;
                        end
                    end
                end
                ST_CLADE_A: begin
                    r_c0    <= cl;
                    r_state <= ST_CLADE_B;
                end
                ST_CLADE_B: begin
                    r_clades[NW'(r_i)] <= r_c0 | cl;
                    if (r_i + 1'b1 == nodes) begin
                        r_i     <= eff_n;
                        r_sum   <= '0;
                        r_state <= ST_SCORE_A;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= ST_CLADE_A;
                    end
                end
                ST_SCORE_A: begin
                    r_c0    <= cl;
                    r_state <= ST_SCORE_B;
                end
                ST_SCORE_B: begin
                    r_key <= {r_c0 | cl, canon};
                    if (limit == '0) begin
                        r_found <= 1'b0;
                        r_state <= ST_EMIT;
                    end else begin
                        r_state <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    if (srch.done) begin
                        r_found <= srch.found;
                        r_idx   <= srch_idx;
                        if (srch.found) begin
                            r_sum <= sum_sat;
                        end
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        if (r_i + 1'b1 == nodes) begin
                            for (int j = 0; j < INT_SLOTS; j++) begin
                                r_first[j]  <= NO_CHILD;
                                r_second[j] <= NO_CHILD;
                            end
                            r_next  <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= ST_SCORE_A;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit_go) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_out_slot <= SLOT_W'(slot_full);
            r_out_idx  <= r_found ? IDX_W'(r_idx) : '0;
            r_out_stat <= ~r_found;
            r_out_sum  <= r_sum;
            r_out_last <= (r_i + 1'b1 == nodes);
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_internal_slot  = r_out_slot;
    assign o_matched_index  = r_out_idx;
    assign o_status         = r_out_stat;
    assign o_log_prob_total = r_out_sum;
    assign o_last_res       = r_out_last;

`ifndef SYNTHESIS
    a_last_starts_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_cmd == CMD_PARENT && i_last) |=> r_state == ST_CLADE_A)
        else $error("last item did not start clade rebuild");
    a_done_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        srch.done |-> r_state == ST_SEARCH)
        else $error("search response outside search");
    a_node_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> (r_i >= eff_n) && (r_i < nodes))
        else $error("internal node id out of range");
    a_emit_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_go |=> r_out_vld)
        else $error("emitted result not held");
`endif

endmodule

FILE: sim/spt_checker.sv
`timescale 1ns / 100ps

module spt_checker
    import spt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [10:0]               i_cfg_wdata,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [1:0]                i_cmd,
    input  logic [IDX_W-1:0]          i_entry_index,
    input  logic [CLADE_W-1:0]        i_parent_clade_bits,
    input  logic [CLADE_W-1:0]        i_child_clade_bits,
    input  logic signed [LP_W-1:0]    i_entry_log_prob,
    input  logic [NODE_ID_W-1:0]      i_parent_node,
    input  logic                      i_last,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [SLOT_W-1:0]         i_internal_slot,
    input  logic [IDX_W-1:0]          i_matched_index,
    input  logic                      i_status,
    input  logic signed [SUM_W-1:0]   i_log_prob_total,
    input  logic                      i_last_res,
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam int TABLE_DEPTH = 1024;
    localparam longint SUM_HI = 64'sd34359738367;
    localparam longint SUM_LO = -64'sd34359738368;

    typedef struct packed {
        logic [SLOT_W-1:0]       slot;
        logic [IDX_W-1:0]        index;
        logic                    miss;
        logic signed [SUM_W-1:0] total;
        logic                    root;
    } t_node_score;

    logic [31:0]          key_mem [TABLE_DEPTH];
    logic [31:0]          lp_mem [TABLE_DEPTH];
    logic [NODE_ID_W-1:0] left_kid [15];
    logic [NODE_ID_W-1:0] right_kid [15];
    logic [NODE_ID_W-1:0] child_ptr;
    logic [4:0]           taxa_reg;
    logic [10:0]          entries_reg;
    t_node_score          score_q[$];

    function automatic int taxa_count();
        int n;
        n = taxa_reg;
        if (n < 2) n = 2;
        if (n > 16) n = 16;
        return n;
    endfunction

    task automatic note_fail(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    task automatic clear_tree();
        for (int s = 0; s < 15; s++) begin
            left_kid[s]  = NO_CHILD;
            right_kid[s] = NO_CHILD;
        end
        child_ptr = '0;
    endtask

    // rebuild clades, look up every internal node, queue one score per node
    task automatic score_tree();
        logic [31:0] clade [31];
        logic [31:0] c0, c1, l0, l1, canon, key;
        int          n, nodes, span, hit;
        longint      acc;
        t_node_score s;
        n     = taxa_count();
        nodes = 2 * n - 1;
        span  = (entries_reg > TABLE_DEPTH) ? TABLE_DEPTH : entries_reg;
        for (int i = 0; i < 31; i++) clade[i] = (i < n) ? (32'd1 << i) : 32'd0;
        for (int i = n; i < nodes; i++) begin
            c0 = (left_kid[i-n] < nodes) ? clade[left_kid[i-n]] : 32'd0;
            c1 = (right_kid[i-n] < nodes) ? clade[right_kid[i-n]] : 32'd0;
            clade[i] = c0 | c1;
        end
        acc = 0;
        for (int i = n; i < nodes; i++) begin
            c0 = (left_kid[i-n] < nodes) ? clade[left_kid[i-n]] : 32'd0;
            c1 = (right_kid[i-n] < nodes) ? clade[right_kid[i-n]] : 32'd0;
            l0 = c0 & (~c0 + 32'd1);
            l1 = c1 & (~c1 + 32'd1);
            canon = (l0 < l1) ? c0 : c1;
            key = {c0[15:0] | c1[15:0], canon[15:0]};
            hit = -1;
            for (int k = 0; k < span; k++)
                if (key_mem[k] === key) hit = k;
            if (hit >= 0) begin
                acc += longint'($signed(lp_mem[hit]));
                if (acc > SUM_HI) acc = SUM_HI;
                if (acc < SUM_LO) acc = SUM_LO;
            end
            s.slot  = SLOT_W'(i - n);
            s.index = (hit >= 0) ? IDX_W'(hit) : '0;
            s.miss  = (hit < 0);
            s.total = SUM_W'(acc);
            s.root  = (i == nodes - 1);
            score_q.push_back(s);
        end
        clear_tree();
    endtask

    task automatic take_item();
        int n, nodes, slot;
        case (t_cmd'(i_cmd))
            CMD_WRITE: begin
                key_mem[i_entry_index] = {i_parent_clade_bits, i_child_clade_bits};
                lp_mem[i_entry_index]  = i_entry_log_prob;
            end
            CMD_LPROB: lp_mem[i_entry_index] = i_entry_log_prob;
            CMD_PARENT: begin
                n     = taxa_count();
                nodes = 2 * n - 1;
                if (child_ptr < nodes - 1 && i_parent_node >= n && i_parent_node < nodes) begin
                    slot = i_parent_node - n;
                    if (left_kid[slot] == NO_CHILD) left_kid[slot] = child_ptr;
                    else right_kid[slot] = child_ptr;
                end
                if (child_ptr != 5'd31) child_ptr = child_ptr + 5'd1;
                if (i_last) score_tree();
            end
            default: ;
        endcase
    endtask

    task automatic check_score();
        t_node_score e;
        if (score_q.size() == 0) begin
            note_fail($sformatf("unexpected result slot %0d", i_internal_slot));
            return;
        end
        e = score_q.pop_front();
        if (i_internal_slot !== e.slot)
            note_fail($sformatf("slot %0d, want %0d", i_internal_slot, e.slot));
        if (i_matched_index !== e.index)
            note_fail($sformatf("slot %0d index %0d, want %0d", e.slot, i_matched_index,
                                e.index));
        if (i_status !== e.miss)
            note_fail($sformatf("slot %0d status %0b, want %0b", e.slot, i_status, e.miss));
        if (i_log_prob_total !== e.total)
            note_fail($sformatf("slot %0d total %0d, want %0d", e.slot, i_log_prob_total,
                                e.total));
        if (i_last_res !== e.root)
            note_fail($sformatf("slot %0d root flag %0b, want %0b", e.slot, i_last_res,
                                e.root));
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // follow config writes and both channels on every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_tree();
            taxa_reg    = 5'd16;
            entries_reg = 11'd1024;
            score_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (t_reg'(i_cfg_idx) == REG_TAXA) taxa_reg = i_cfg_wdata[4:0];
                else entries_reg = i_cfg_wdata;
            end
            if (i_out_valid && i_out_ready) check_score();
            if (i_in_valid && i_in_ready) take_item();
        end
        o_pending = score_q.size();
    end

endmodule

FILE: sim/tb_subsplit_topology_log_prob.sv
`timescale 1ns / 100ps

module tb_subsplit_topology_log_prob;
    import spt_pkg::*;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic                    cfg_idx = 1'b0;
    logic [10:0]             cfg_wdata = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [1:0]              cmd = '0;
    logic [IDX_W-1:0]        entry_index = '0;
    logic [CLADE_W-1:0]      parent_bits = '0;
    logic [CLADE_W-1:0]      child_bits = '0;
    logic signed [LP_W-1:0]  entry_lp = '0;
    logic [NODE_ID_W-1:0]    parent_node = '0;
    logic                    last = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [SLOT_W-1:0]       internal_slot;
    logic [IDX_W-1:0]        matched_index;
    logic                    status;
    logic signed [SUM_W-1:0] lp_total;
    logic                    last_res;
    int                      fail_count;
    int                      pending;

    bit                      filled [1024];
    int                      cur_taxa = 16;
    int                      cur_span = 1024;
    int                      burst_left = 0;
    int                      stall_tick = 0;
    int                      stall_mode = 0;
    int                      tree_parent [32];

    always #2 i_clk = ~i_clk;

    subsplit_topology_log_prob u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_idx          (cfg_idx),
        .i_cfg_wdata        (cfg_wdata),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_cmd              (cmd),
        .i_entry_index      (entry_index),
        .i_parent_clade_bits(parent_bits),
        .i_child_clade_bits (child_bits),
        .i_entry_log_prob   (entry_lp),
        .i_parent_node      (parent_node),
        .i_last             (last),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_internal_slot    (internal_slot),
        .o_matched_index    (matched_index),
        .o_status           (status),
        .o_log_prob_total   (lp_total),
        .o_last_res         (last_res)
    );

    spt_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_idx          (cfg_idx),
        .i_cfg_wdata        (cfg_wdata),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_cmd              (cmd),
        .i_entry_index      (entry_index),
        .i_parent_clade_bits(parent_bits),
        .i_child_clade_bits (child_bits),
        .i_entry_log_prob   (entry_lp),
        .i_parent_node      (parent_node),
        .i_last             (last),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_internal_slot    (internal_slot),
        .i_matched_index    (matched_index),
        .i_status           (status),
        .i_log_prob_total   (lp_total),
        .i_last_res         (last_res),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // stall the result side, switching between always ready, random and rarely ready
    always @(negedge i_clk) begin
        stall_tick++;
        if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // one transfer on the input channel, in bursts with random gaps
    task automatic send(input t_cmd c, input int idx, input logic [15:0] pc,
                        input logic [15:0] cc, input logic [31:0] lp,
                        input int pn, input bit lst);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        cmd         = c;
        entry_index = IDX_W'(idx);
        parent_bits = pc;
        child_bits  = cc;
        entry_lp    = lp;
        parent_node = NODE_ID_W'(pn);
        last        = lst;
        in_valid    = 1'b1;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        if (c == CMD_WRITE) filled[idx] = 1'b1;
    endtask

    task automatic put_entry(input int idx, input logic [15:0] pc, input logic [15:0] cc,
                             input logic [31:0] lp);
        send(CMD_WRITE, idx, pc, cc, lp, $urandom_range(0, 31), 1'($urandom_range(0, 1)));
    endtask

    task automatic link(input int pn, input bit lst);
        send(CMD_PARENT, $urandom_range(0, 1023), 16'($urandom), 16'($urandom), $urandom,
             pn, lst);
    endtask

    // drain results, then let the block settle before touching config
    task automatic settle();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_reg(input t_reg r, input int val);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_idx   = r;
        cfg_wdata = 11'(val);
        @(negedge i_clk);
        cfg_we    = 1'b0;
        if (r == REG_TAXA) begin
            cur_taxa = val % 32;
            if (cur_taxa < 2) cur_taxa = 2;
            if (cur_taxa > 16) cur_taxa = 16;
        end else begin
            cur_span = (val > 1024) ? 1024 : val;
        end
    endtask

    // every searched entry must hold something before a tree is scored
    task automatic fill_span();
        for (int k = 0; k < cur_span; k++)
            if (!filled[k]) put_entry(k, 16'($urandom), 16'($urandom), $urandom);
    endtask

    // random well-formed topology by merging pairs; root gets the top id
    task automatic make_tree();
        int pool[$];
        int a, b, n;
        n = cur_taxa;
        pool.delete();
        for (int i = 0; i < n; i++) pool.push_back(i);
        for (int k = n; k < 2 * n - 1; k++) begin
            a = $urandom_range(0, pool.size() - 1);
            tree_parent[pool[a]] = k;
            pool.delete(a);
            b = $urandom_range(0, pool.size() - 1);
            tree_parent[pool[b]] = k;
            pool.delete(b);
            pool.push_back(k);
        end
    endtask

    // store keys for most internal nodes so lookups mostly hit
    task automatic seed_keys(input int hit_pct);
        logic [15:0] clade [31];
        logic [15:0] c0, c1, canon;
        int          kid0 [31];
        int          kid1 [31];
        int          n;
        n = cur_taxa;
        for (int i = 0; i < 31; i++) begin
            clade[i] = (i < n) ? (16'd1 << i) : 16'd0;
            kid0[i]  = -1;
            kid1[i]  = -1;
        end
        for (int i = 0; i < 2 * n - 2; i++) begin
            if (kid0[tree_parent[i]] < 0) kid0[tree_parent[i]] = i;
            else kid1[tree_parent[i]] = i;
        end
        for (int k = n; k < 2 * n - 1; k++) begin
            c0 = clade[kid0[k]];
            c1 = clade[kid1[k]];
            clade[k] = c0 | c1;
            canon = ((c0 & -c0) < (c1 & -c1)) ? c0 : c1;
            if (cur_span > 0 && $urandom_range(1, 100) <= hit_pct)
                put_entry($urandom_range(0, cur_span - 1), c0 | c1, canon, $urandom);
        end
    endtask

    task automatic play_tree();
        for (int i = 0; i < 2 * cur_taxa - 2; i++)
            link(tree_parent[i], i == 2 * cur_taxa - 3);
    endtask

    // malformed trees: bad parents, short or long sequences, noise commands
    task automatic broken_tree();
        int len;
        len = $urandom_range(1, 2 * cur_taxa + 2);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 5))
                0: send(CMD_NONE, $urandom_range(0, 1023), 16'($urandom), 16'($urandom),
                        $urandom, $urandom_range(0, 31), 1'($urandom_range(0, 1)));
                1: send(CMD_LPROB, $urandom_range(0, 1023), 16'($urandom), 16'($urandom),
                        $urandom, $urandom_range(0, 31), 1'($urandom_range(0, 1)));
                2: link($urandom_range(0, 31), 1'b0);
                default: link($urandom_range(cur_taxa, 2 * cur_taxa - 2), 1'b0);
            endcase
        end
        link($urandom_range(0, 31), 1'b1);
    endtask

    task automatic random_phase(input int trees);
        for (int t = 0; t < trees; t++) begin
            if ($urandom_range(0, 4) == 0) begin
                broken_tree();
            end else begin
                make_tree();
                seed_keys($urandom_range(50, 100));
                if (cur_span > 0 && $urandom_range(0, 1))
                    send(CMD_LPROB, $urandom_range(0, cur_span - 1), 16'($urandom),
                         16'($urandom), $urandom, $urandom_range(0, 31),
                         1'($urandom_range(0, 1)));
                play_tree();
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: two taxa, four entries searched
        set_reg(REG_TAXA, 2);
        set_reg(REG_ENTRIES, 4);
        put_entry(0, 16'hFFFF, 16'h0000, 32'h8000_0000);
        put_entry(1, 16'h0003, 16'h0001, 32'h7FFF_FFFF);
        put_entry(2, 16'h0000, 16'hFFFF, 32'h0000_0000);
        put_entry(3, 16'h0003, 16'h0001, 32'h0001_0000);
        put_entry(1023, 16'hA5A5, 16'h5A5A, 32'hFFFF_FFFF);
        send(CMD_NONE, 5, 16'h1234, 16'h4321, 32'h1, 0, 1'b1);
        link(2, 1'b0);
        link(2, 1'b1);                       // duplicate keys: highest index wins
        send(CMD_LPROB, 3, 16'h0, 16'h0, 32'h8000_0000, 0, 1'b0);
        link(2, 1'b0);
        link(2, 1'b1);
        send(CMD_WRITE, 3, 16'h0003, 16'h0002, 32'h0000_1000, 0, 1'b0);
        send(CMD_WRITE, 1, 16'h0007, 16'h0001, 32'h0000_1000, 0, 1'b0);
        link(2, 1'b0);
        link(2, 1'b1);                       // key gone: not found
        link(2, 1'b1);                       // lone child, other side empty
        link(31, 1'b0);
        link(0, 1'b1);                       // parent not internal
        link(2, 1'b0);
        link(2, 1'b0);
        link(2, 1'b0);
        link(2, 1'b1);                       // extra links past the node count
        settle();

        // sweep taxa and table size, extremes included
        set_reg(REG_TAXA, 31);
        set_reg(REG_ENTRIES, 20);
        fill_span();
        random_phase(1);
        settle();
        set_reg(REG_TAXA, 0);
        set_reg(REG_ENTRIES, 0);
        random_phase(3);
        settle();
        set_reg(REG_TAXA, 5);
        set_reg(REG_ENTRIES, 1);
        random_phase(2);
        settle();
        set_reg(REG_TAXA, 3);
        set_reg(REG_ENTRIES, 24);
        fill_span();
        random_phase(4);
        settle();

        if (fail_count == 0) begin
            $display("tb_subsplit_topology_log_prob: clean");
        end else begin
            $display("tb_subsplit_topology_log_prob: errors");
        end
        $finish;
    end

    // hard stop if the run hangs
    initial begin
        #12_000_000;
        $display("tb_subsplit_topology_log_prob: errors");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/spt_pkg.sv
rtl/core/spt_table.sv
rtl/core/subsplit_topology_log_prob.sv
sim/spt_checker.sv
sim/tb_subsplit_topology_log_prob.sv
